FILE: hw/rtl/fhi_pkg.sv
// Shared types, constants and code tables for the fixed Huffman inflate block.
// Used by fhi_lit_dec and fixed_huffman_inflate; depends on nothing.
`default_nettype none
package fhi_pkg;

	localparam int WINDOW_BYTES = 32768;
	localparam int WIN_AW = $clog2(WINDOW_BYTES);
	localparam int LANE_BYTES = 8;

	typedef enum logic [1:0] {
		ST_DATA = 2'd0,
		ST_EOB  = 2'd1,
		ST_ERR  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		PH_LIT,
		PH_LEN_X,
		PH_DIST,
		PH_DIST_X
	} phase_t;

	typedef struct packed {
		logic       need;
		logic [8:0] sym;
		logic [3:0] nbits;
	} sym_t;

	function automatic logic [8:0] len_base(input logic [4:0] i);
		logic [8:0] r;
		case (i)
			5'd0: r = 9'd3;    5'd1: r = 9'd4;    5'd2: r = 9'd5;    5'd3: r = 9'd6;
			5'd4: r = 9'd7;    5'd5: r = 9'd8;    5'd6: r = 9'd9;    5'd7: r = 9'd10;
			5'd8: r = 9'd11;   5'd9: r = 9'd13;   5'd10: r = 9'd15;  5'd11: r = 9'd17;
			5'd12: r = 9'd19;  5'd13: r = 9'd23;  5'd14: r = 9'd27;  5'd15: r = 9'd31;
			5'd16: r = 9'd35;  5'd17: r = 9'd43;  5'd18: r = 9'd51;  5'd19: r = 9'd59;
			5'd20: r = 9'd67;  5'd21: r = 9'd83;  5'd22: r = 9'd99;  5'd23: r = 9'd115;
			5'd24: r = 9'd131; 5'd25: r = 9'd163; 5'd26: r = 9'd195; 5'd27: r = 9'd227;
			5'd28: r = 9'd258;
			default: r = 9'd3;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] len_extra(input logic [4:0] i);
		logic [2:0] r;
		if (i < 5'd8 || i == 5'd28 || i > 5'd28) begin
			r = 3'd0;
		end else begin
			r = 3'(((i - 5'd4) >> 2));
		end
		return r;
	endfunction

	function automatic logic [15:0] dist_base(input logic [4:0] c);
		logic [15:0] r;
		case (c)
			5'd0: r = 16'd1;      5'd1: r = 16'd2;      5'd2: r = 16'd3;
			5'd3: r = 16'd4;      5'd4: r = 16'd5;      5'd5: r = 16'd7;
			5'd6: r = 16'd9;      5'd7: r = 16'd13;     5'd8: r = 16'd17;
			5'd9: r = 16'd25;     5'd10: r = 16'd33;    5'd11: r = 16'd49;
			5'd12: r = 16'd65;    5'd13: r = 16'd97;    5'd14: r = 16'd129;
			5'd15: r = 16'd193;   5'd16: r = 16'd257;   5'd17: r = 16'd385;
			5'd18: r = 16'd513;   5'd19: r = 16'd769;   5'd20: r = 16'd1025;
			5'd21: r = 16'd1537;  5'd22: r = 16'd2049;  5'd23: r = 16'd3073;
			5'd24: r = 16'd4097;  5'd25: r = 16'd6145;  5'd26: r = 16'd8193;
			5'd27: r = 16'd12289; 5'd28: r = 16'd16385; 5'd29: r = 16'd24577;
			default: r = 16'd1;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] dist_extra(input logic [4:0] c);
		logic [3:0] r;
		if (c < 5'd4 || c > 5'd29) begin
			r = 4'd0;
		end else begin
			r = 4'(((c - 5'd2) >> 1));
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/fhi_lit_dec.sv
// Literal/length code decoder for the fixed Huffman code.
// Uses fhi_pkg for the result type.
`default_nettype none
module fhi_lit_dec (
	input  wire logic [8:0]    head_bits,
	input  wire logic [5:0]    fill,
	output fhi_pkg::sym_t      res
);

	logic [6:0] c7;
	logic [7:0] c8;
	logic [8:0] c9;

	always_comb begin
		for (int i = 0; i < 7; i++) c7[i] = head_bits[6 - i];
		for (int i = 0; i < 8; i++) c8[i] = head_bits[7 - i];
		for (int i = 0; i < 9; i++) c9[i] = head_bits[8 - i];
	end

	always_comb begin
		res.need  = 1'b0;
		res.sym   = '0;
		res.nbits = 4'd0;
		priority if (fill < 6'd7) begin
			res.need = 1'b1;
		end else if (c7 <= 7'd23) begin
			res.sym   = 9'd256 + {2'b00, c7};
			res.nbits = 4'd7;
		end else if (fill < 6'd8) begin
			res.need = 1'b1;
		end else if (c8 >= 8'd48 && c8 <= 8'd191) begin
			res.sym   = {1'b0, c8 - 8'd48};
			res.nbits = 4'd8;
		end else if (c8 >= 8'd192 && c8 <= 8'd199) begin
			res.sym   = 9'd280 + {6'b0, c8[2:0]};
			res.nbits = 4'd8;
		end else if (fill < 6'd9) begin
			res.need = 1'b1;
		end else begin
			res.sym   = {1'b0, c9[7:0]};
			res.nbits = 4'd9;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/fixed_huffman_inflate.sv
// Top level of the fixed Huffman DEFLATE block decoder with its 32 KiB history window.
// Depends on fhi_pkg and fhi_lit_dec.
//
// Compressed words enter on item_valid/item_ready, up to eight stream bits each,
// first bit in bit zero; start_block clears the decoder before the bits are taken.
// Decoded bytes leave on result_valid/result_ready in words of up to eight bytes,
// with status data, end of block or error; run_last marks the last result word of
// an input word. output_limit (limit_q) is written through cfg_wr_en/cfg_wr_data;
// the user must write it only while idle, since the block does not enforce this.
// An input word enters in S_IDLE; S_DEC then decodes its symbols and extra-bit
// fields, and each copied byte is read from the window in S_CP_RD and written back
// in S_CP_WR through the single port history memory; once the bits are used up,
// S_FLUSH and S_FIN close out the word.
// Results are held one word deep so that run_last can be set on the final one;
// a result word moves to the output register when the next one is produced or
// when the input word closes.
// When the receiver stalls while a result word is held, decoding pauses and
// item_ready stays low until every result of the current word has reached the
// output register.
// Reset clears all control state; the history memory is not cleared, since only
// bytes written in the current block are ever read.
`default_nettype none
module fixed_huffman_inflate (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic [7:0]  in_bits,
	input  wire logic [3:0]  bit_count,
	input  wire logic        start_block,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [63:0]      out_bytes,
	output logic [3:0]       byte_count,
	output logic [1:0]       status,
	output logic             run_last
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DEC,
		S_CP_RD,
		S_CP_WR,
		S_FLUSH,
		S_FIN
	} state_t;

	localparam int AW = fhi_pkg::WIN_AW;

	logic [7:0] win_mem [fhi_pkg::WINDOW_BYTES];
	logic [7:0] rd_q;

	state_t            st_q, nx_st;
	logic [31:0]       bitbuf_q, nx_bitbuf;
	logic [5:0]        fill_q, nx_fill;
	fhi_pkg::phase_t   ph_q, nx_ph;
	logic [8:0]        plen_q, nx_plen;
	logic [4:0]        dcode_q, nx_dcode;
	logic [15:0]       dist_q, nx_dist;
	logic [8:0]        cnt_q, nx_cnt;
	logic [31:0]       bw_q, nx_bw;
	logic              done_q, nx_done;
	logic              err_q, nx_err;
	logic [31:0]       limit_q;
	logic [63:0]       lane_q, nx_lane, lane_ins;
	logic [3:0]        lane_n_q, nx_lane_n;

	logic              hold_v_q;
	logic [63:0]       hold_bytes_q;
	logic [3:0]        hold_cnt_q;
	fhi_pkg::status_t  hold_stat_q;
	logic              out_v_q;
	logic [63:0]       out_bytes_q;
	logic [3:0]        out_cnt_q;
	fhi_pkg::status_t  out_stat_q;
	logic              out_last_q;

	logic              out_free, can_emit;
	logic              em_v, fin_v, pb_v, fail_v, cp_v;
	logic [63:0]       em_bytes;
	logic [3:0]        em_cnt;
	fhi_pkg::status_t  em_stat;
	logic [7:0]        pb_byte;
	logic [15:0]       cp_d;
	logic [3:0]        cnt_in;
	logic [7:0]        bits_in;
	logic [6:0]        fill_sum;
	logic [4:0]        li;
	logic [8:0]        lsym;
	logic [4:0]        c5;
	logic [3:0]        ext_n;
	logic [12:0]       peek;
	logic [AW-1:0]     rd_addr;
	logic [31:0]       rd_diff;
	fhi_pkg::sym_t     sd;

	fhi_lit_dec u_lit_dec (
		.head_bits (bitbuf_q[8:0]),
		.fill      (fill_q),
		.res       (sd)
	);

	assign out_free   = !out_v_q || result_ready;
	assign can_emit   = !hold_v_q || out_free;
	assign item_ready = (st_q == S_IDLE);

	assign cnt_in   = (bit_count > 4'd8) ? 4'd8 : bit_count;
	assign bits_in  = in_bits & 8'((9'd1 << cnt_in) - 9'd1);
	assign lsym     = sd.sym - 9'd257;
	assign li       = lsym[4:0];
	assign rd_diff  = bw_q - {16'b0, dist_q};
	assign rd_addr  = rd_diff[AW-1:0];

	always_comb begin
		for (int i = 0; i < 5; i++) c5[i] = bitbuf_q[4 - i];
	end

	always_comb begin
		lane_ins = lane_q;
		lane_ins[{lane_n_q[2:0], 3'b000} +: 8] = pb_byte;
	end

	always_comb begin
		nx_st     = st_q;
		nx_bitbuf = bitbuf_q;
		nx_fill   = fill_q;
		nx_ph     = ph_q;
		nx_plen   = plen_q;
		nx_dcode  = dcode_q;
		nx_dist   = dist_q;
		nx_cnt    = cnt_q;
		nx_bw     = bw_q;
		nx_done   = done_q;
		nx_err    = err_q;
		nx_lane   = lane_q;
		nx_lane_n = lane_n_q;
		em_v      = 1'b0;
		em_bytes  = lane_q;
		em_cnt    = lane_n_q;
		em_stat   = fhi_pkg::ST_DATA;
		fin_v     = 1'b0;
		pb_v      = 1'b0;
		pb_byte   = rd_q;
		fail_v    = 1'b0;
		cp_v      = 1'b0;
		cp_d      = '0;
		ext_n     = 4'd0;
		peek      = '0;
		fill_sum  = '0;
		unique case (st_q)
			S_IDLE: begin
				if (item_valid) begin
					if (start_block) begin
						nx_bitbuf = '0;
						nx_fill   = '0;
						nx_ph     = fhi_pkg::PH_LIT;
						nx_plen   = '0;
						nx_dcode  = '0;
						nx_bw     = '0;
						nx_done   = 1'b0;
						nx_err    = 1'b0;
					end
					if (!start_block && err_q) begin
						em_v     = 1'b1;
						em_bytes = '0;
						em_cnt   = '0;
						em_stat  = fhi_pkg::ST_ERR;
						nx_st    = S_FIN;
					end else if (!start_block && done_q) begin
						nx_st = S_IDLE;
					end else begin
						fill_sum = {1'b0, nx_fill} + {3'b0, cnt_in};
						if (fill_sum <= 7'd32) begin
							if (nx_fill < 6'd32) begin
								nx_bitbuf = nx_bitbuf | ({24'b0, bits_in} << nx_fill[4:0]);
							end
							nx_fill = fill_sum[5:0];
						end
						nx_st = S_DEC;
					end
				end
			end
			S_DEC: begin
				if (can_emit) begin
					unique case (ph_q)
						fhi_pkg::PH_LIT: begin
							if (sd.need) begin
								nx_st = S_FLUSH;
							end else begin
								nx_bitbuf = bitbuf_q >> sd.nbits;
								nx_fill   = fill_q - {2'b0, sd.nbits};
								if (!sd.sym[8]) begin
									if (bw_q >= limit_q) begin
										fail_v = 1'b1;
									end else begin
										pb_v    = 1'b1;
										pb_byte = sd.sym[7:0];
									end
								end else if (sd.sym == 9'd256) begin
									nx_done = 1'b1;
									em_v    = 1'b1;
									em_stat = fhi_pkg::ST_EOB;
									nx_st   = S_FLUSH;
								end else if (sd.sym >= 9'd286) begin
									fail_v = 1'b1;
								end else if (fhi_pkg::len_extra(li) == 3'd0) begin
									nx_plen = fhi_pkg::len_base(li);
									nx_ph   = fhi_pkg::PH_DIST;
								end else begin
									nx_plen = {4'b0, li};
									nx_ph   = fhi_pkg::PH_LEN_X;
								end
							end
						end
						fhi_pkg::PH_LEN_X: begin
							ext_n = {1'b0, fhi_pkg::len_extra(plen_q[4:0])};
							peek  = bitbuf_q[12:0] & 13'((14'd1 << ext_n) - 14'd1);
							if (fill_q < {2'b0, ext_n}) begin
								nx_st = S_FLUSH;
							end else begin
								nx_plen   = fhi_pkg::len_base(plen_q[4:0]) + peek[8:0];
								nx_bitbuf = bitbuf_q >> ext_n;
								nx_fill   = fill_q - {2'b0, ext_n};
								nx_ph     = fhi_pkg::PH_DIST;
							end
						end
						fhi_pkg::PH_DIST: begin
							if (fill_q < 6'd5) begin
								nx_st = S_FLUSH;
							end else begin
								nx_bitbuf = bitbuf_q >> 5;
								nx_fill   = fill_q - 6'd5;
								if (c5 >= 5'd30) begin
									nx_ph  = fhi_pkg::PH_LIT;
									fail_v = 1'b1;
								end else if (fhi_pkg::dist_extra(c5) == 4'd0) begin
									cp_v = 1'b1;
									cp_d = fhi_pkg::dist_base(c5);
								end else begin
									nx_dcode = c5;
									nx_ph    = fhi_pkg::PH_DIST_X;
								end
							end
						end
						fhi_pkg::PH_DIST_X: begin
							ext_n = fhi_pkg::dist_extra(dcode_q);
							peek  = bitbuf_q[12:0] & 13'((14'd1 << ext_n) - 14'd1);
							if (fill_q < {2'b0, ext_n}) begin
								nx_st = S_FLUSH;
							end else begin
								cp_v      = 1'b1;
								cp_d      = fhi_pkg::dist_base(dcode_q) + {3'b0, peek};
								nx_bitbuf = bitbuf_q >> ext_n;
								nx_fill   = fill_q - {2'b0, ext_n};
							end
						end
						default: nx_st = S_FLUSH;
					endcase
					if (cp_v) begin
						nx_ph = fhi_pkg::PH_LIT;
						if ({16'b0, cp_d} > bw_q) begin
							fail_v = 1'b1;
						end else if (({1'b0, bw_q} + {24'b0, plen_q}) > {1'b0, limit_q}) begin
							fail_v = 1'b1;
						end else begin
							nx_dist = cp_d;
							nx_cnt  = plen_q;
							nx_st   = S_CP_RD;
						end
					end
					if (fail_v) begin
						nx_err  = 1'b1;
						em_v    = 1'b1;
						em_stat = fhi_pkg::ST_ERR;
						nx_st   = S_FLUSH;
					end
					if (em_v) begin
						nx_lane   = '0;
						nx_lane_n = '0;
					end
				end
			end
			S_CP_RD: begin
				nx_st = S_CP_WR;
			end
			S_CP_WR: begin
				if (can_emit) begin
					pb_v   = 1'b1;
					nx_cnt = cnt_q - 9'd1;
					nx_st  = (cnt_q == 9'd1) ? S_DEC : S_CP_RD;
				end
			end
			S_FLUSH: begin
				if (can_emit) begin
					if (lane_n_q != 4'd0) begin
						em_v      = 1'b1;
						nx_lane   = '0;
						nx_lane_n = '0;
					end
					nx_st = S_FIN;
				end
			end
			S_FIN: begin
				if (!hold_v_q) begin
					nx_st = S_IDLE;
				end else if (out_free) begin
					fin_v = 1'b1;
					nx_st = S_IDLE;
				end
			end
			default: nx_st = S_IDLE;
		endcase
		if (pb_v) begin
			nx_bw = bw_q + 32'd1;
			if (lane_n_q == 4'(fhi_pkg::LANE_BYTES - 1)) begin
				em_v      = 1'b1;
				em_bytes  = lane_ins;
				em_cnt    = 4'(fhi_pkg::LANE_BYTES);
				em_stat   = fhi_pkg::ST_DATA;
				nx_lane   = '0;
				nx_lane_n = '0;
			end else begin
				nx_lane   = lane_ins;
				nx_lane_n = lane_n_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pb_v) begin
			win_mem[bw_q[AW-1:0]] <= pb_byte;
		end
		if (st_q == S_CP_RD) begin
			rd_q <= win_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			bitbuf_q     <= '0;
			fill_q       <= '0;
			ph_q         <= fhi_pkg::PH_LIT;
			plen_q       <= '0;
			dcode_q      <= '0;
			dist_q       <= '0;
			cnt_q        <= '0;
			bw_q         <= '0;
			done_q       <= 1'b0;
			err_q        <= 1'b0;
			limit_q      <= 32'hFFFF_FFFF;
			lane_q       <= '0;
			lane_n_q     <= '0;
			hold_v_q     <= 1'b0;
			hold_bytes_q <= '0;
			hold_cnt_q   <= '0;
			hold_stat_q  <= fhi_pkg::ST_DATA;
			out_v_q      <= 1'b0;
			out_bytes_q  <= '0;
			out_cnt_q    <= '0;
			out_stat_q   <= fhi_pkg::ST_DATA;
			out_last_q   <= 1'b0;
		end else begin
			st_q     <= nx_st;
			bitbuf_q <= nx_bitbuf;
			fill_q   <= nx_fill;
			ph_q     <= nx_ph;
			plen_q   <= nx_plen;
			dcode_q  <= nx_dcode;
			dist_q   <= nx_dist;
			cnt_q    <= nx_cnt;
			bw_q     <= nx_bw;
			done_q   <= nx_done;
			err_q    <= nx_err;
			lane_q   <= nx_lane;
			lane_n_q <= nx_lane_n;
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (result_ready) begin
				out_v_q <= 1'b0;
			end
			if (em_v) begin
				if (hold_v_q) begin
					out_v_q     <= 1'b1;
					out_bytes_q <= hold_bytes_q;
					out_cnt_q   <= hold_cnt_q;
					out_stat_q  <= hold_stat_q;
					out_last_q  <= 1'b0;
				end
				hold_v_q     <= 1'b1;
				hold_bytes_q <= em_bytes;
				hold_cnt_q   <= em_cnt;
				hold_stat_q  <= em_stat;
			end else if (fin_v) begin
				out_v_q     <= 1'b1;
				out_bytes_q <= hold_bytes_q;
				out_cnt_q   <= hold_cnt_q;
				out_stat_q  <= hold_stat_q;
				out_last_q  <= 1'b1;
				hold_v_q    <= 1'b0;
			end
		end
	end

	assign result_valid = out_v_q;
	assign out_bytes    = out_bytes_q;
	assign byte_count   = out_cnt_q;
	assign status       = out_stat_q;
	assign run_last     = out_last_q;

endmodule
`default_nettype wire
